// ===== sv/gsmc_pkg.sv =====
`timescale 1ns / 1ps

package gsmc_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    localparam logic [3:0] MODE_EMPTY       = 4'd0;
    localparam logic [3:0] MODE_AWAIT       = 4'd1;
    localparam logic [3:0] MODE_LOADING     = 4'd2;
    localparam logic [3:0] MODE_READY       = 4'd3;
    localparam logic [3:0] MODE_COUPLED     = 4'd4;
    localparam logic [3:0] MODE_TRANSIT     = 4'd5;
    localparam logic [3:0] MODE_PRINTER     = 4'd6;
    localparam logic [3:0] MODE_CATCHING    = 4'd7;
    localparam logic [3:0] MODE_ASSIGNED    = 4'd8;
    localparam logic [3:0] MODE_UNADDRESSED = 4'd9;
    localparam logic [3:0] MODE_FAULT       = 4'd10;

    localparam logic [2:0] OPC_GRIP      = 3'd0;
    localparam logic [2:0] OPC_RELEASE   = 3'd1;
    localparam logic [2:0] OPC_INPRINTER = 3'd2;
    localparam logic [2:0] OPC_EJECT     = 3'd3;
    localparam logic [2:0] OPC_AWAIT     = 3'd4;
    localparam logic [2:0] OPC_PING      = 3'd5;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd1;

    localparam logic [1:0] GC_NONE = 2'd0;
    localparam logic [1:0] GC_GRIP = 2'd1;
    localparam logic [1:0] GC_OPEN = 2'd2;

    localparam logic [2:0] LED_IDLE_EMPTY   = 3'd0;
    localparam logic [2:0] LED_GRIP_PENDING = 3'd1;
    localparam logic [2:0] LED_IDLE_READY   = 3'd2;
    localparam logic [2:0] LED_LOAD_FEED    = 3'd3;
    localparam logic [2:0] LED_FEED_STUCK   = 3'd4;
    localparam logic [2:0] LED_ERROR        = 3'd5;

    localparam logic [2:0] REG_STUCK_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_SETTLE        = 3'd1;
    localparam logic [2:0] REG_FEED_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_GRIP_PULSE    = 3'd3;
    localparam logic [2:0] REG_OPEN_PULSE    = 3'd4;

    localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] SETTLE_RST        = 16'd300;
    localparam logic [15:0] FEED_TIMEOUT_RST  = 16'd5000;
    localparam logic [11:0] GRIP_PULSE_RST    = 12'd2000;
    localparam logic [11:0] OPEN_PULSE_RST    = 12'd1000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        sensor;
        logic [31:0] now_ms;
        logic        op;
    } in_item_t;

    // bit o set: opcode o allowed in that mode
    function automatic logic [7:0] legal_ops(input logic [3:0] mode);
        logic [7:0] mask;
        unique case (mode)
            MODE_EMPTY:    mask = 8'h30;
            MODE_AWAIT:    mask = 8'h31;
            MODE_LOADING:  mask = 8'h20;
            MODE_READY:    mask = 8'h33;
            MODE_COUPLED:  mask = 8'h26;
            MODE_TRANSIT:  mask = 8'h24;
            MODE_PRINTER:  mask = 8'h2A;
            MODE_CATCHING: mask = 8'h2C;
            default:       mask = 8'h00;
        endcase
        return mask;
    endfunction

    function automatic logic [2:0] led_of_mode(input logic [3:0] mode);
        logic [2:0] led;
        unique case (mode)
            MODE_LOADING, MODE_COUPLED: led = LED_GRIP_PENDING;
            MODE_READY, MODE_PRINTER:   led = LED_IDLE_READY;
            MODE_TRANSIT:               led = LED_LOAD_FEED;
            MODE_CATCHING:              led = LED_FEED_STUCK;
            MODE_FAULT:                 led = LED_ERROR;
            default:                    led = LED_IDLE_EMPTY;
        endcase
        return led;
    endfunction

endpackage

// ===== sv/gripper_slot_mode_controller_unit.sv =====
`timescale 1ns / 1ps

// Mode controller for one filament gripper slot. Each input transaction is either a
// tick (tuser 0) carrying a millisecond timestamp and the filament sensor level, or a
// command (tuser 1) carrying an opcode; every input transaction yields exactly one
// result transaction with mode, command status, stored error, LED state, gripper move,
// servo pulse target, sensor level and the settle and feed deadlines. An item is held in
// the input register and then evaluated into the result register; one item is taken
// every cycle while the receiver accepts results; a stalled result holds the input item.
// Configuration registers are written through the cfg port, which is always ready; the
// user must write them only while no item is in flight; the block does not enforce it.
module gripper_slot_mode_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], sensor[32], opcode[35:33], zero pad
    input  logic [gsmc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // mode[3:0], status[5:4], last_error[6], led_code[9:7], gripper_cmd[11:10],
    // servo_target_us[23:12], sensor_stable[24], settle_deadline_ms[56:25],
    // feed_deadline_ms[88:57], zero pad
    output logic [gsmc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gsmc_pkg::*;

    logic [15:0] stuck_timeout_reg, settle_reg, feed_timeout_reg;
    logic [11:0] grip_pulse_reg, open_pulse_reg;

    logic        in_vld_reg;
    in_item_t    in_reg;
    logic        out_vld_reg;
    logic [88:0] out_reg;

    logic [3:0]  mode_reg, mode_next;
    logic        sensor_prev_reg, sensor_prev_next;
    logic        gripper_closed_reg, gripper_closed_next;
    logic [31:0] edge_time_reg, edge_time_next;
    logic        error_reg, error_next;
    logic [11:0] servo_target_reg, servo_target_next;
    logic [31:0] settle_deadline_reg, settle_deadline_next;
    logic [31:0] feed_deadline_reg, feed_deadline_next;
    logic [1:0]  status_next, gcmd_next;

    logic        out_free, fire;
    logic [31:0] settle_sum, feed_sum, elapsed;
    logic [7:0]  legal_mask;

    assign out_free  = !out_vld_reg || m_tready;
    assign fire      = in_vld_reg && out_free;
    assign s_tready  = !in_vld_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {7'd0, out_reg};

    assign settle_sum = in_reg.now_ms + {16'd0, settle_reg};
    assign feed_sum   = in_reg.now_ms + {16'd0, feed_timeout_reg};
    assign legal_mask = legal_ops(mode_reg);

    always_comb begin
        mode_next            = mode_reg;
        sensor_prev_next     = sensor_prev_reg;
        gripper_closed_next  = gripper_closed_reg;
        edge_time_next       = edge_time_reg;
        error_next           = error_reg;
        servo_target_next    = servo_target_reg;
        settle_deadline_next = settle_deadline_reg;
        feed_deadline_next   = feed_deadline_reg;
        status_next          = STATUS_OK;
        gcmd_next            = GC_NONE;
        elapsed              = 32'd0;
        if (in_reg.op == OP_TICK) begin
            if (!sensor_prev_reg && in_reg.sensor) begin
                if (mode_reg == MODE_EMPTY || mode_reg == MODE_AWAIT) begin
                    mode_next            = MODE_LOADING;
                    gcmd_next            = GC_GRIP;
                    settle_deadline_next = settle_sum;
                end
            end else if (sensor_prev_reg && !in_reg.sensor) begin
                if (mode_reg == MODE_PRINTER) begin
                    mode_next            = MODE_CATCHING;
                    gcmd_next            = GC_GRIP;
                    settle_deadline_next = settle_sum;
                    feed_deadline_next   = feed_sum;
                end
            end
            if (in_reg.sensor != sensor_prev_reg) begin
                edge_time_next = in_reg.now_ms;
            end
            sensor_prev_next = in_reg.sensor;
            elapsed          = in_reg.now_ms - edge_time_next;
            if (mode_next != MODE_FAULT && gcmd_next != GC_GRIP && !gripper_closed_reg
                    && in_reg.sensor && edge_time_next != 32'd0
                    && elapsed > {16'd0, stuck_timeout_reg}) begin
                mode_next  = MODE_FAULT;
                error_next = 1'b1;
            end
        end else if (!legal_mask[in_reg.opcode]) begin
            status_next = STATUS_ILLEGAL;
        end else begin
            unique case (in_reg.opcode)
                OPC_GRIP: begin
                    if (mode_reg == MODE_AWAIT || mode_reg == MODE_READY) begin
                        mode_next            = MODE_COUPLED;
                        gcmd_next            = GC_GRIP;
                        settle_deadline_next = settle_sum;
                    end
                end
                OPC_RELEASE: begin
                    if (mode_reg == MODE_COUPLED || mode_reg == MODE_PRINTER
                            || mode_reg == MODE_CATCHING) begin
                        mode_next            = MODE_READY;
                        gcmd_next            = GC_OPEN;
                        settle_deadline_next = settle_sum;
                    end
                end
                OPC_INPRINTER: begin
                    if (mode_reg == MODE_COUPLED || mode_reg == MODE_TRANSIT
                            || mode_reg == MODE_CATCHING) begin
                        mode_next = MODE_PRINTER;
                    end
                end
                OPC_EJECT: begin
                    if (mode_reg == MODE_PRINTER || mode_reg == MODE_CATCHING) begin
                        mode_next = MODE_AWAIT;
                        gcmd_next = GC_OPEN;
                    end
                end
                OPC_AWAIT: begin
                    mode_next = MODE_AWAIT;
                    gcmd_next = GC_OPEN;
                end
                default: begin
                end
            endcase
        end
        if (gcmd_next == GC_GRIP) begin
            gripper_closed_next = 1'b1;
            servo_target_next   = grip_pulse_reg;
        end else if (gcmd_next == GC_OPEN) begin
            gripper_closed_next = 1'b0;
            servo_target_next   = open_pulse_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stuck_timeout_reg <= STUCK_TIMEOUT_RST;
            settle_reg        <= SETTLE_RST;
            feed_timeout_reg  <= FEED_TIMEOUT_RST;
            grip_pulse_reg    <= GRIP_PULSE_RST;
            open_pulse_reg    <= OPEN_PULSE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STUCK_TIMEOUT: stuck_timeout_reg <= cfg_data;
                REG_SETTLE:        settle_reg        <= cfg_data;
                REG_FEED_TIMEOUT:  feed_timeout_reg  <= cfg_data;
                REG_GRIP_PULSE:    grip_pulse_reg    <= cfg_data[11:0];
                REG_OPEN_PULSE:    open_pulse_reg    <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            mode_reg            <= MODE_EMPTY;
            sensor_prev_reg     <= 1'b0;
            gripper_closed_reg  <= 1'b0;
            edge_time_reg       <= 32'd0;
            error_reg           <= 1'b0;
            servo_target_reg    <= OPEN_PULSE_RST;
            settle_deadline_reg <= 32'd0;
            feed_deadline_reg   <= 32'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (fire) begin
                mode_reg            <= mode_next;
                sensor_prev_reg     <= sensor_prev_next;
                gripper_closed_reg  <= gripper_closed_next;
                edge_time_reg       <= edge_time_next;
                error_reg           <= error_next;
                servo_target_reg    <= servo_target_next;
                settle_deadline_reg <= settle_deadline_next;
                feed_deadline_reg   <= feed_deadline_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= {s_tdata[35:33], s_tdata[32], s_tdata[31:0], s_tuser};
        end
        if (fire) begin
            out_reg <= {feed_deadline_next, settle_deadline_next, sensor_prev_next,
                        servo_target_next, gcmd_next, led_of_mode(mode_next),
                        error_next, status_next, mode_next};
        end
    end

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_FAULT |=> mode_reg == MODE_FAULT)
        else $error("fault mode left");

    a_error_means_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |-> mode_reg == MODE_FAULT)
        else $error("stored error without fault mode");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_free |=> in_vld_reg && $stable(in_reg))
        else $error("stalled input item lost");

    a_grip_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && gcmd_next == GC_GRIP |=> gripper_closed_reg)
        else $error("grip move did not close gripper");

    a_illegal_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && status_next == STATUS_ILLEGAL |=> $stable(mode_reg) && $stable(servo_target_reg))
        else $error("rejected command changed state");

endmodule

// ===== tb/gripper_slot_mode_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module gripper_slot_mode_controller_unit_tb;
    import gsmc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 190;
    localparam logic [2:0] OPC_UNKNOWN6 = 3'd6;
    localparam logic [2:0] OPC_UNKNOWN7 = 3'd7;

    typedef struct packed {
        logic [3:0]  mode;
        logic        sensor_prev;
        logic        jaw_closed;
        logic [31:0] edge_ms;
        logic        err;
        logic [11:0] servo;
        logic [31:0] settle_dl;
        logic [31:0] feed_dl;
        logic [1:0]  status;
        logic [1:0]  gcmd;
    } slot_state_t;

    typedef struct packed {
        logic [31:0] feed_dl;
        logic [31:0] settle_dl;
        logic        sensor;
        logic [11:0] servo;
        logic [1:0]  gcmd;
        logic [2:0]  led;
        logic        err;
        logic [1:0]  status;
        logic [3:0]  mode;
    } slot_result_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        sensor;
        logic [2:0]  opcode;
        logic        pin;
        logic [3:0]  mode;
        logic [1:0]  status;
        logic        err;
    } step_row_t;

    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HALF, RX_SPARSE} rx_style_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // now_ms, sensor, opcode, zero pad
    logic        s_tuser = 1'b0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [95:0] m_tdata;          // mode, status, last_error, led_code, gripper_cmd,
                                   // servo_target_us, sensor_stable, settle, feed, pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_STUCK_TIMEOUT;
    logic [15:0] cfg_data = '0;

    logic [15:0] stuck_lim = STUCK_TIMEOUT_RST;
    logic [15:0] settle_span = SETTLE_RST;
    logic [15:0] feed_lim = FEED_TIMEOUT_RST;
    logic [11:0] grip_us = GRIP_PULSE_RST;
    logic [11:0] open_us = OPEN_PULSE_RST;

    slot_state_t  slot;
    slot_result_t status_due [$];
    slot_result_t want_frame;
    slot_result_t got_frame;
    int           err_cnt = 0;
    int           quiet_cycles = 0;
    int           burst_left = 0;
    int           step_max = 2000;
    logic [31:0]  clock_ms = 32'd1;
    logic         trap_ok = 1'b0;
    rx_style_e    rx_style = RX_FLOW;
    int           rx_left = 0;

    step_row_t script [0:24] = '{
        '{OP_COMMAND, 32'd0,         1'b0, OPC_PING,      1'b1, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd1,         1'b0, OPC_UNKNOWN6,  1'b1, MODE_EMPTY,    STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'hFFFF_FFFF, 1'b1, OPC_UNKNOWN7,  1'b1, MODE_EMPTY,    STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'd2,         1'b0, OPC_GRIP,      1'b1, MODE_EMPTY,    STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'd2,         1'b0, OPC_RELEASE,   1'b1, MODE_EMPTY,    STATUS_ILLEGAL, 1'b0},
        '{OP_TICK,    32'd3,         1'b0, OPC_UNKNOWN7,  1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd10,        1'b0, OPC_AWAIT,     1'b1, MODE_AWAIT,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd11,        1'b0, OPC_INPRINTER, 1'b1, MODE_AWAIT,    STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'hFFFF_FF00, 1'b0, OPC_GRIP,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'hFFFF_FF10, 1'b0, OPC_INPRINTER, 1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'hFFFF_FF20, 1'b1, OPC_GRIP,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'hFFFF_FFF0, 1'b0, OPC_GRIP,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd4,         1'b0, OPC_GRIP,      1'b1, MODE_CATCHING, STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'd5,         1'b0, OPC_INPRINTER, 1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd6,         1'b0, OPC_EJECT,     1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd7,         1'b0, OPC_GRIP,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd8,         1'b0, OPC_RELEASE,   1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'd0,         1'b1, OPC_PING,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'hFFFF_FFFF, 1'b1, OPC_PING,      1'b1, MODE_READY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'd100,       1'b0, OPC_PING,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'd200,       1'b1, OPC_PING,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'd5200,      1'b1, OPC_PING,      1'b1, MODE_READY,    STATUS_OK,      1'b0},
        '{OP_TICK,    32'd5201,      1'b0, OPC_PING,      1'b0, MODE_EMPTY,    STATUS_OK,      1'b0},
        '{OP_COMMAND, 32'd5300,      1'b1, OPC_EJECT,     1'b1, MODE_READY,    STATUS_ILLEGAL, 1'b0},
        '{OP_COMMAND, 32'd5301,      1'b0, OPC_RELEASE,   1'b1, MODE_READY,    STATUS_OK,      1'b0}
    };

    gripper_slot_mode_controller_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic cmd_allowed(input logic [3:0] m, input logic [2:0] c);
        case (m)
            MODE_EMPTY:    return c == OPC_AWAIT || c == OPC_PING;
            MODE_AWAIT:    return c == OPC_GRIP || c == OPC_AWAIT || c == OPC_PING;
            MODE_LOADING:  return c == OPC_PING;
            MODE_READY:    return c == OPC_GRIP || c == OPC_RELEASE || c == OPC_AWAIT
                                  || c == OPC_PING;
            MODE_COUPLED:  return c == OPC_RELEASE || c == OPC_INPRINTER || c == OPC_PING;
            MODE_TRANSIT:  return c == OPC_INPRINTER || c == OPC_PING;
            MODE_PRINTER:  return c == OPC_RELEASE || c == OPC_EJECT || c == OPC_PING;
            MODE_CATCHING: return c == OPC_INPRINTER || c == OPC_EJECT || c == OPC_PING;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] led_for(input logic [3:0] m);
        case (m)
            MODE_LOADING, MODE_COUPLED: return LED_GRIP_PENDING;
            MODE_READY, MODE_PRINTER:   return LED_IDLE_READY;
            MODE_TRANSIT:               return LED_LOAD_FEED;
            MODE_CATCHING:              return LED_FEED_STUCK;
            MODE_FAULT:                 return LED_ERROR;
            default:                    return LED_IDLE_EMPTY;
        endcase
    endfunction

    function automatic slot_state_t jaw_move(input slot_state_t s, input logic close);
        slot_state_t n;
        n = s;
        n.jaw_closed = close;
        n.servo = close ? grip_us : open_us;
        n.gcmd = close ? GC_GRIP : GC_OPEN;
        return n;
    endfunction

    function automatic slot_state_t slot_advance(input slot_state_t s, input in_item_t it);
        slot_state_t n;
        logic [31:0] elapsed;
        n = s;
        n.status = STATUS_OK;
        n.gcmd = GC_NONE;
        if (it.op == OP_TICK) begin
            if (!s.sensor_prev && it.sensor) begin
                if (s.mode == MODE_EMPTY || s.mode == MODE_AWAIT) begin
                    n.mode = MODE_LOADING;
                    n = jaw_move(n, 1'b1);
                    n.settle_dl = it.now_ms + {16'd0, settle_span};
                end
            end else if (s.sensor_prev && !it.sensor && s.mode == MODE_PRINTER) begin
                n.mode = MODE_CATCHING;
                n = jaw_move(n, 1'b1);
                n.settle_dl = it.now_ms + {16'd0, settle_span};
                n.feed_dl = it.now_ms + {16'd0, feed_lim};
            end
            if (it.sensor != s.sensor_prev)
                n.edge_ms = it.now_ms;
            n.sensor_prev = it.sensor;
            elapsed = it.now_ms - n.edge_ms;
            if (n.mode != MODE_FAULT && !n.jaw_closed && it.sensor && n.edge_ms != 32'd0
                && elapsed > {16'd0, stuck_lim}) begin
                n.mode = MODE_FAULT;
                n.err = 1'b1;
            end
        end else if (!cmd_allowed(s.mode, it.opcode)) begin
            n.status = STATUS_ILLEGAL;
        end else begin
            case (it.opcode)
                OPC_GRIP: begin
                    if (s.mode == MODE_AWAIT || s.mode == MODE_READY) begin
                        n.mode = MODE_COUPLED;
                        n = jaw_move(n, 1'b1);
                        n.settle_dl = it.now_ms + {16'd0, settle_span};
                    end
                end
                OPC_RELEASE: begin
                    if (s.mode == MODE_COUPLED || s.mode == MODE_PRINTER
                        || s.mode == MODE_CATCHING) begin
                        n.mode = MODE_READY;
                        n = jaw_move(n, 1'b0);
                        n.settle_dl = it.now_ms + {16'd0, settle_span};
                    end
                end
                OPC_INPRINTER: begin
                    if (s.mode == MODE_COUPLED || s.mode == MODE_TRANSIT
                        || s.mode == MODE_CATCHING)
                        n.mode = MODE_PRINTER;
                end
                OPC_EJECT: begin
                    if (s.mode == MODE_PRINTER || s.mode == MODE_CATCHING) begin
                        n.mode = MODE_AWAIT;
                        n = jaw_move(n, 1'b0);
                    end
                end
                OPC_AWAIT: begin
                    n.mode = MODE_AWAIT;
                    n = jaw_move(n, 1'b0);
                end
                default: begin
                end
            endcase
        end
        return n;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    task automatic issue(input in_item_t it, input logic pin, input logic [3:0] pin_mode,
                         input logic [1:0] pin_status, input logic pin_err);
        slot_result_t want;
        int gap;
        slot = slot_advance(slot, it);
        want.mode = slot.mode;
        want.status = slot.status;
        want.err = slot.err;
        want.led = led_for(slot.mode);
        want.gcmd = slot.gcmd;
        want.servo = slot.servo;
        want.sensor = slot.sensor_prev;
        want.settle_dl = slot.settle_dl;
        want.feed_dl = slot.feed_dl;
        if (pin) begin
            want.mode = pin_mode;
            want.status = pin_status;
            want.err = pin_err;
        end
        status_due.push_back(want);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata <= {4'd0, it.opcode, it.sensor, it.now_ms};
        s_tuser <= it.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pick_item(output in_item_t it);
        int tries;
        it.op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_COMMAND;
        if ($urandom_range(0, 49) == 0) begin
            it.now_ms = $urandom();
        end else begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            it.now_ms = clock_ms;
        end
        it.opcode = 3'($urandom_range(0, 7));
        if (it.op == OP_TICK) begin
            it.sensor = ($urandom_range(0, 2) == 0) ? ~slot.sensor_prev : slot.sensor_prev;
        end else begin
            it.sensor = 1'($urandom_range(0, 1));
            // mostly legal commands so the mode graph is walked deeply
            if ($urandom_range(0, 4) != 0)
                for (tries = 0; tries < 16 && !cmd_allowed(slot.mode, it.opcode); tries++)
                    it.opcode = 3'($urandom_range(0, 7));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STUCK_TIMEOUT: stuck_lim = val;
            REG_SETTLE:        settle_span = val;
            REG_FEED_TIMEOUT:  feed_lim = val;
            REG_GRIP_PULSE:    grip_us = val[11:0];
            REG_OPEN_PULSE:    open_us = val[11:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_settings(input logic [15:0] stuck_v, input logic [15:0] settle_v,
                                 input logic [15:0] feed_v, input logic [15:0] grip_v,
                                 input logic [15:0] open_v);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(REG_STUCK_TIMEOUT, stuck_v);
        write_reg(REG_SETTLE, settle_v);
        write_reg(REG_FEED_TIMEOUT, feed_v);
        write_reg(REG_GRIP_PULSE, grip_v);
        write_reg(REG_OPEN_PULSE, open_v);
        cfg_valid <= 1'b0;
    endtask

    // receiver backpressure in one of four random styles, switched when a random countdown runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style <= rx_style_e'(2'($urandom_range(0, 3)));
            rx_left <= $urandom_range(16, 128);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_FLOW:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_tready <= ($urandom_range(0, 1) != 0);
            default:  m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                $error("result transaction with nothing pending");
                err_cnt++;
            end else begin
                want_frame = status_due.pop_front();
                got_frame = m_tdata[88:0];
                cmp_field("mode", 32'(want_frame.mode), 32'(got_frame.mode));
                cmp_field("status", 32'(want_frame.status), 32'(got_frame.status));
                cmp_field("last_error", 32'(want_frame.err), 32'(got_frame.err));
                cmp_field("led_code", 32'(want_frame.led), 32'(got_frame.led));
                cmp_field("gripper_cmd", 32'(want_frame.gcmd), 32'(got_frame.gcmd));
                cmp_field("servo_target_us", 32'(want_frame.servo), 32'(got_frame.servo));
                cmp_field("sensor_stable", 32'(want_frame.sensor), 32'(got_frame.sensor));
                cmp_field("settle_deadline_ms", want_frame.settle_dl, got_frame.settle_dl);
                cmp_field("feed_deadline_ms", want_frame.feed_dl, got_frame.feed_dl);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[gripper_slot_mode_controller_unit] ERROR");
            $finish;
        end
    end

    initial begin
        in_item_t    it;
        slot_state_t trial;
        logic        bad;
        int          tries;
        slot = '0;
        slot.mode = MODE_EMPTY;
        slot.servo = OPEN_PULSE_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            it.op = script[i].op;
            it.now_ms = script[i].now_ms;
            it.sensor = script[i].sensor;
            it.opcode = script[i].opcode;
            issue(it, script[i].pin, script[i].mode, script[i].status, script[i].err);
        end

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                end
                1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                 16'($urandom_range(500, 2500)),
                                 16'($urandom_range(500, 2500)));
                4: load_settings(16'd1, 16'hFFFF, 16'd1, 16'd500, 16'd2500);
                5: load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                 16'($urandom()), 16'($urandom()));
                default: begin
                    // closing phase: the dead-end modes are allowed from here on
                    load_settings(16'($urandom_range(50, 500)), 16'($urandom()),
                                  16'($urandom()), 16'($urandom_range(500, 2500)),
                                  16'($urandom_range(500, 2500)));
                    trap_ok = 1'b1;
                end
            endcase
            step_max = (ph == 2) ? 30000 : $urandom_range(1, 3000);
            if ($urandom_range(0, 1) == 0)
                clock_ms = 32'hFFFF_8000;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                bad = 1'b1;
                for (tries = 0; tries < 20 && bad; tries++) begin
                    pick_item(it);
                    trial = slot_advance(slot, it);
                    bad = !trap_ok && trial.mode != slot.mode
                          && (trial.mode == MODE_LOADING || trial.mode == MODE_FAULT);
                end
                if (bad) begin
                    it.op = OP_COMMAND;
                    it.opcode = OPC_PING;
                end
                issue(it, 1'b0, MODE_EMPTY, STATUS_OK, 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("[gripper_slot_mode_controller_unit] OK");
        else
            $display("[gripper_slot_mode_controller_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/gsmc_pkg.sv
sv/gripper_slot_mode_controller_unit.sv
tb/gripper_slot_mode_controller_unit_tb.sv
